>>> rtl/core/lsb_pkg.sv
// Package for the bounded lowest-score buffer: field widths, operation codes,
// compare result type and the default store depth.
// No dependencies.
package lsb_pkg;

   localparam int unsigned LSB_DEPTH_DEFAULT = 16;
   localparam int unsigned OP_W              = 2;
   localparam int unsigned SCORE_W           = 32;
   localparam int unsigned ID_W              = 24;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR  = 2'd0,
      OP_INSERT = 2'd1,
      OP_QUERY  = 2'd2
   } op_type;

   typedef struct packed {
      logic eq;
      logic lt;
      logic gt;
   } cmp_res_type;

endpackage

>>> rtl/core/lsb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stands alone; no package needed.
module lsb_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/lsb_cmp.sv
// Shared score comparator used by every scan of the buffer.
// Depends on lsb_pkg for the score width and the result struct.
module lsb_cmp import lsb_pkg::*; (
   input  logic [SCORE_W-1:0] cmp_a,
   input  logic [SCORE_W-1:0] cmp_b,
   output cmp_res_type        cmp_res
);

   always_comb begin
      cmp_res.eq = (cmp_a == cmp_b);
      cmp_res.lt = (cmp_a <  cmp_b);
      cmp_res.gt = (cmp_a >  cmp_b);
   end

endmodule

>>> rtl/core/bounded_lowest_score_buffer.sv
// Top level of the bounded lowest-score buffer: sequencer, store and response register.
// Depends on lsb_pkg, lsb_ram and lsb_cmp.
//
// Usage: items enter on req_* (valid/stall), results leave on rsp_* (valid/stall),
// exactly one result per item. Operations: clear, insert, query; code 3 is a no-op.
// The store is one RAM of BUFFER_DEPTH (score, id) entries, walked one entry per
// cycle through the shared comparator.
// Clear, unused code, query of an empty store, insert while not full and a rejected
// insert are answered from the idle state; rsp_valid rises in the cycle after accept.
// A query reads each held entry in turn (registered RAM read) and keeps the lowest score.
// A replacing insert searches for the worst entry, overwrites it, then rescans the
// whole store for the new worst.
// One item is in work at a time; req_stall is high while a scan runs or while a
// result waits in the output register under rsp_stall.
// Reset empties the store (fill and worst score cleared) and drops any result;
// the RAM itself is not cleared. A stalled result holds its value until taken.
module bounded_lowest_score_buffer import lsb_pkg::*; #(
   parameter int unsigned BUFFER_DEPTH = LSB_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [OP_W-1:0]    req_operation,
   input  logic [SCORE_W-1:0] req_entry_score,
   input  logic [ID_W-1:0]    req_entry_id,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_kept,
   output logic               rsp_is_empty,
   output logic [ID_W-1:0]    rsp_best_id,
   output logic [SCORE_W-1:0] rsp_best_score
);

   localparam int unsigned IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(BUFFER_DEPTH + 1);
   localparam int unsigned ENT_W = SCORE_W + ID_W;
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(BUFFER_DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FIND,
      ST_MAXS,
      ST_QRY
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [SCORE_W-1:0] worst_ff, worst_in;
   logic [SCORE_W-1:0] run_ff, run_in;
   logic [ID_W-1:0]    run_id_ff, run_id_in;
   logic [SCORE_W-1:0] new_score_ff, new_score_in;
   logic [ID_W-1:0]    new_id_ff, new_id_in;
   logic [CNT_W-1:0]   rd_cnt_ff, rd_cnt_in;
   logic               chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]   chk_idx_ff, chk_idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_kept_ff, rsp_kept_in;
   logic               rsp_empty_ff, rsp_empty_in;
   logic [ID_W-1:0]    rsp_id_ff, rsp_id_in;
   logic [SCORE_W-1:0] rsp_score_ff, rsp_score_in;

   logic               ram_we;
   logic [IDX_W-1:0]   ram_waddr;
   logic [ENT_W-1:0]   ram_wdata;
   logic [IDX_W-1:0]   ram_raddr;
   logic [ENT_W-1:0]   ram_rdata;
   logic [SCORE_W-1:0] rd_score;
   logic [ID_W-1:0]    rd_id;

   logic [SCORE_W-1:0] cmp_a;
   logic [SCORE_W-1:0] cmp_b;
   cmp_res_type        cmp_res;

   logic               accept;
   logic               slot_free;
   logic               rsp_load;
   logic [CNT_W-1:0]   scan_limit;
   logic               issue;
   logic               scan_done;

   lsb_ram #(
      .WIDTH (ENT_W),
      .DEPTH (BUFFER_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   lsb_cmp u_cmp (
      .cmp_a   (cmp_a),
      .cmp_b   (cmp_b),
      .cmp_res (cmp_res)
   );

   assign rd_score  = ram_rdata[ENT_W-1:ID_W];
   assign rd_id     = ram_rdata[ID_W-1:0];
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !slot_free;
   assign accept    = req_valid && !req_stall;

   assign scan_limit = (state_ff == ST_QRY) ? fill_ff : FULL_CNT;
   assign issue      = (rd_cnt_ff != scan_limit);
   assign scan_done  = !issue && !chk_vld_ff;

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      worst_in     = worst_ff;
      run_in       = run_ff;
      run_id_in    = run_id_ff;
      new_score_in = new_score_ff;
      new_id_in    = new_id_ff;
      rd_cnt_in    = rd_cnt_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = rd_cnt_ff[IDX_W-1:0];
      ram_we       = 1'b0;
      ram_waddr    = chk_idx_ff;
      ram_wdata    = {new_score_ff, new_id_ff};
      ram_raddr    = rd_cnt_ff[IDX_W-1:0];
      cmp_a        = rd_score;
      cmp_b        = worst_ff;
      rsp_load     = 1'b0;
      rsp_kept_in  = 1'b0;
      rsp_empty_in = 1'b0;
      rsp_id_in    = '0;
      rsp_score_in = '0;

      case (state_ff)
         ST_IDLE: begin
            cmp_a     = req_entry_score;
            rd_cnt_in = '0;
            if (accept) begin
               case (op_type'(req_operation))
                  OP_CLEAR: begin
                     fill_in      = '0;
                     worst_in     = '0;
                     rsp_load     = 1'b1;
                     rsp_empty_in = 1'b1;
                  end
                  OP_INSERT: begin
                     if (fill_ff != FULL_CNT) begin
                        ram_we      = 1'b1;
                        ram_waddr   = fill_ff[IDX_W-1:0];
                        ram_wdata   = {req_entry_score, req_entry_id};
                        fill_in     = fill_ff + CNT_W'(1);
                        if (cmp_res.gt) begin
                           worst_in = req_entry_score;
                        end
                        rsp_load    = 1'b1;
                        rsp_kept_in = 1'b1;
                     end else if (cmp_res.lt) begin
                        new_score_in = req_entry_score;
                        new_id_in    = req_entry_id;
                        state_in     = ST_FIND;
                     end else begin
                        rsp_load = 1'b1;
                     end
                  end
                  OP_QUERY: begin
                     if (fill_ff == '0) begin
                        rsp_load     = 1'b1;
                        rsp_empty_in = 1'b1;
                     end else begin
                        state_in = ST_QRY;
                     end
                  end
                  default: begin
                     rsp_load     = 1'b1;
                     rsp_empty_in = (fill_ff == '0);
                  end
               endcase
            end
         end
         ST_FIND: begin
            if (issue) begin
               rd_cnt_in  = rd_cnt_ff + CNT_W'(1);
               chk_vld_in = 1'b1;
            end
            if (chk_vld_ff && cmp_res.eq) begin
               ram_we     = 1'b1;
               rd_cnt_in  = '0;
               chk_vld_in = 1'b0;
               run_in     = '0;
               state_in   = ST_MAXS;
            end else if (scan_done) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_MAXS: begin
            cmp_b = run_ff;
            if (issue) begin
               rd_cnt_in  = rd_cnt_ff + CNT_W'(1);
               chk_vld_in = 1'b1;
            end
            if (chk_vld_ff && cmp_res.gt) begin
               run_in = rd_score;
            end
            if (scan_done) begin
               worst_in    = run_ff;
               rsp_load    = 1'b1;
               rsp_kept_in = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_QRY: begin
            cmp_b = run_ff;
            if (issue) begin
               rd_cnt_in  = rd_cnt_ff + CNT_W'(1);
               chk_vld_in = 1'b1;
            end
            if (chk_vld_ff && ((chk_idx_ff == '0) || cmp_res.lt)) begin
               run_in    = rd_score;
               run_id_in = rd_id;
            end
            if (scan_done) begin
               rsp_load     = 1'b1;
               rsp_id_in    = run_id_ff;
               rsp_score_in = run_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         worst_ff     <= '0;
         rd_cnt_ff    <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         worst_ff     <= worst_in;
         rd_cnt_ff    <= rd_cnt_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      run_ff       <= run_in;
      run_id_ff    <= run_id_in;
      new_score_ff <= new_score_in;
      new_id_ff    <= new_id_in;
      chk_idx_ff   <= chk_idx_in;
      if (rsp_load) begin
         rsp_kept_ff  <= rsp_kept_in;
         rsp_empty_ff <= rsp_empty_in;
         rsp_id_ff    <= rsp_id_in;
         rsp_score_ff <= rsp_score_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kept       = rsp_kept_ff;
   assign rsp_is_empty   = rsp_empty_ff;
   assign rsp_best_id    = rsp_id_ff;
   assign rsp_best_score = rsp_score_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL_CNT)
      else $error("fill count beyond store depth");

   a_find_only_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIND) |-> (fill_ff == FULL_CNT))
      else $error("replacement search while store not full");

   a_load_slot_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> slot_free)
      else $error("result overwrites an untaken result");

   a_query_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_QRY && chk_vld_ff) |-> (CNT_W'(chk_idx_ff) < fill_ff))
      else $error("query reads beyond held entries");

   a_scan_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |=> !$past(accept))
      else $error("item accepted during a scan");

endmodule

>>> tb/bounded_lowest_score_buffer_test.sv
// Self-checking testbench for bounded_lowest_score_buffer: directed and random
// clear/insert/query/unused-code items. A scoreboard class predicts each result.
// Depends on lsb_pkg and the bounded_lowest_score_buffer RTL.
module bounded_lowest_score_buffer_test;
   timeunit 1ns;
   timeprecision 1ps;
   import lsb_pkg::*;

   localparam int unsigned DEPTH        = LSB_DEPTH_DEFAULT;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int unsigned PHASES       = 5;
   localparam int unsigned PHASE_ITEMS  = 305;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned DRAIN_CYCLES = 2 * DEPTH + 10;
   localparam int unsigned CYCLE_LIMIT  = 1000000;

   typedef struct packed {
      logic               kept;
      logic               is_empty;
      logic [ID_W-1:0]    best_id;
      logic [SCORE_W-1:0] best_score;
   } buffer_reply_type;

   class score_buffer_model;
      logic [SCORE_W-1:0] score_mem [DEPTH];
      logic [ID_W-1:0]    id_mem [DEPTH];
      int unsigned        fill;
      logic [SCORE_W-1:0] worst;
      buffer_reply_type   replies_due [$];
      int unsigned        mismatches;

      function new();
         fill       = 0;
         worst      = '0;
         mismatches = 0;
      endfunction

      function int unsigned pending();
         return replies_due.size();
      endfunction

      function void accept_item(logic [OP_W-1:0] op, logic [SCORE_W-1:0] score,
                                logic [ID_W-1:0] id);
         buffer_reply_type r;
         bit               done;
         r    = '0;
         done = 1'b0;
         case (op)
            OP_CLEAR: begin
               fill  = 0;
               worst = '0;
            end
            OP_INSERT: begin
               if (fill < DEPTH) begin
                  score_mem[fill] = score;
                  id_mem[fill]    = id;
                  fill++;
                  if (score > worst) worst = score;
                  r.kept = 1'b1;
               end else if (score < worst) begin
                  for (int i = 0; i < DEPTH; i++) begin
                     if (!done && score_mem[i] == worst) begin
                        score_mem[i] = score;
                        id_mem[i]    = id;
                        done         = 1'b1;
                     end
                  end
                  if (done) begin
                     worst = '0;
                     for (int i = 0; i < DEPTH; i++)
                        if (score_mem[i] > worst) worst = score_mem[i];
                     r.kept = 1'b1;
                  end
               end
            end
            OP_QUERY: begin
               if (fill > 0) begin
                  r.best_score = score_mem[0];
                  r.best_id    = id_mem[0];
                  for (int i = 1; i < fill; i++) begin
                     if (score_mem[i] < r.best_score) begin
                        r.best_score = score_mem[i];
                        r.best_id    = id_mem[i];
                     end
                  end
               end
            end
            default: ;
         endcase
         r.is_empty = (fill == 0);
         replies_due.push_back(r);
      endfunction

      function void compare_field(string what, logic [SCORE_W-1:0] want,
                                  logic [SCORE_W-1:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %h, got %h", $time, what, want, got);
            mismatches++;
         end
      endfunction

      function void check_reply(buffer_reply_type got);
         buffer_reply_type want;
         if (replies_due.size() == 0) begin
            $display("%0t: unexpected result, kept %b is_empty %b best_id %h best_score %h",
                     $time, got.kept, got.is_empty, got.best_id, got.best_score);
            mismatches++;
            return;
         end
         want = replies_due.pop_front();
         compare_field("kept", SCORE_W'(want.kept), SCORE_W'(got.kept));
         compare_field("is_empty", SCORE_W'(want.is_empty), SCORE_W'(got.is_empty));
         compare_field("best_id", SCORE_W'(want.best_id), SCORE_W'(got.best_id));
         compare_field("best_score", want.best_score, got.best_score);
      endfunction
   endclass

   logic               clock           = 1'b0;
   logic               reset           = 1'b1;
   logic               req_valid       = 1'b0;
   logic               req_stall;
   logic [OP_W-1:0]    req_operation   = '0;
   logic [SCORE_W-1:0] req_entry_score = '0;
   logic [ID_W-1:0]    req_entry_id    = '0;
   logic               rsp_valid;
   logic               rsp_stall       = 1'b0;
   logic               rsp_kept;
   logic               rsp_is_empty;
   logic [ID_W-1:0]    rsp_best_id;
   logic [SCORE_W-1:0] rsp_best_score;

   bit                 send_idle = 1'b0;
   bit                 recv_idle = 1'b0;
   bit                 hold_req  = 1'b0;
   int unsigned        cycle_count = 0;
   score_buffer_model  sb;

   bounded_lowest_score_buffer #(.BUFFER_DEPTH(DEPTH)) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_entry_score (req_entry_score),
      .req_entry_id    (req_entry_id),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kept        (rsp_kept),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_best_id     (rsp_best_id),
      .rsp_best_score  (rsp_best_score)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("bounded_lowest_score_buffer_test: done, errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.accept_item(req_operation, req_entry_score, req_entry_id);
         if (rsp_valid && !rsp_stall)
            sb.check_reply(buffer_reply_type'({rsp_kept, rsp_is_empty, rsp_best_id,
                                               rsp_best_score}));
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r < 12) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [SCORE_W-1:0] pick_score();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom_range(0, 31);
         4, 5, 6:    return $urandom;
         7:          return '0;
         8:          return '1;
         default:    return 32'hFFFF_FFFF - $urandom_range(0, 31);
      endcase
   endfunction

   function automatic logic [ID_W-1:0] pick_id();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         default: return ID_W'($urandom);
      endcase
   endfunction

   function automatic logic [OP_W-1:0] pick_op();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 2)  return OP_CLEAR;
      if (r < 70) return OP_INSERT;
      if (r < 94) return OP_QUERY;
      return OP_UNUSED;
   endfunction

   // receiver: random stall runs, or one long hold when asked
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req   = 1'b0;
            stall_left = HOLD_CYCLES;
         end else if (stall_left == 0 && recv_idle) begin
            stall_left = pick_gap();
         end
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0) stall_left--;
      end
   end

   task automatic send_item(input logic [OP_W-1:0] op, input logic [SCORE_W-1:0] score,
                            input logic [ID_W-1:0] id);
      int unsigned n_gap;
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_entry_score <= score;
      req_entry_id    <= id;
      do @(posedge clock); while (req_stall);
      n_gap = send_idle ? pick_gap() : 0;
      if (n_gap != 0) begin
         req_valid       <= 1'b0;
         req_operation   <= OP_W'($urandom);
         req_entry_score <= $urandom;
         req_entry_id    <= ID_W'($urandom);
         repeat (n_gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   initial begin
      logic [SCORE_W-1:0] score;
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_idle = 1'b1;
      recv_idle = 1'b1;
      send_item(OP_QUERY, '1, '1);
      send_item(OP_UNUSED, '1, '1);
      for (int k = 0; k < DEPTH; k++) begin
         if (k == 0 || k == 2)      score = '1;
         else if (k == 1 || k == 3) score = 32'h10;
         else                       score = 32'h100 + k;
         send_item(OP_INSERT, score, (k == 0) ? '1 : ID_W'(k));
      end
      send_item(OP_QUERY, '0, '0);
      send_item(OP_INSERT, '1, 24'h123456);
      send_item(OP_INSERT, '0, '0);
      send_item(OP_INSERT, '0, 24'h000001);
      send_item(OP_QUERY, '1, '1);
      send_item(OP_UNUSED, '0, '0);
      send_item(OP_CLEAR, '1, '1);
      send_item(OP_QUERY, '0, '0);
      wait_drained();

      for (int phase = 0; phase < PHASES; phase++) begin
         send_idle = (phase == 1) || (phase >= 3);
         recv_idle = (phase >= 2);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (phase == 3 && i == 100) hold_req = 1'b1;
            send_item(pick_op(), pick_score(), pick_id());
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("bounded_lowest_score_buffer_test: done, clean");
      else
         $display("bounded_lowest_score_buffer_test: done, errors");
      $finish;
   end

endmodule

>>> bounded_lowest_score_buffer.f
rtl/core/lsb_pkg.sv
rtl/core/lsb_ram.sv
rtl/core/lsb_cmp.sv
rtl/core/bounded_lowest_score_buffer.sv
tb/bounded_lowest_score_buffer_test.sv
